[hdl/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the RGB 3x3 median filter
// Pixel and channel types, configuration register indexes, size limits and
// the status word that travels from the window builder to the top level.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int DEF_MAX_LINE_PIXELS = 1024;
   localparam int HEIGHT_LIMIT        = 1024;
   localparam int MIN_SIZE            = 3;
   localparam int CSR_W               = 11;
   localparam int ROW_W               = 10;
   localparam int WIN_TAPS            = 9;
   localparam int WIN_COLS_KEPT       = 6;

   localparam logic [CSR_W-1:0] RESET_FRAME_WIDTH  = 11'd320;
   localparam logic [CSR_W-1:0] RESET_FRAME_HEIGHT = 11'd240;

   typedef logic [7:0] chan_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } pixel_type;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // window word waiting at the entry of the median lanes
   typedef struct packed {
      logic valid;
      logic row_end;
      logic frame_end;
   } win_status_type;

endpackage

[hdl/rmf_window.sv]
// ----------------------------------------------------------------------------
// rmf_window: position counters, line stores and 3x3 window assembly
// Tracks row and column, keeps the two previous rows in line stores and the
// two previous window columns in registers, and presents one full window per
// interior pixel together with its row and frame end flags.
// ----------------------------------------------------------------------------
module rmf_window
   import rmf_pkg::*;
#(
   parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  csr_index_type          csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pixel_type              pix_in,
   input  logic                   win_take,
   output win_status_type         win_status,
   output pixel_type [WIN_TAPS-1:0] win_out
);

   localparam int CW = $clog2(MAX_LINE_PIXELS);
   localparam int SW = (CW + 1 > CSR_W) ? CW + 1 : CSR_W;

   logic [CSR_W-1:0] frame_width_ff;
   logic [CSR_W-1:0] frame_height_ff;

   logic [CW-1:0]    col_ff,  col_in;
   logic [ROW_W-1:0] row_ff,  row_in;

   logic [SW-1:0]    width_ext;
   logic [SW-1:0]    width_clamped;
   logic [CSR_W-1:0] height_clamped;
   logic             last_col;
   logic             last_row;
   logic             emit;
   logic             accept;

   // stage 1: pixel just taken and the line store reads for its column
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_emit_ff;
   logic             s1_last_col_ff;
   logic             s1_last_row_ff;
   logic [CW-1:0]    s1_idx_ff;
   pixel_type        s1_pix_ff;
   pixel_type        top_rd_ff;
   pixel_type        mid_rd_ff;
   logic             s1_leave;

   pixel_type        upper_mem  [MAX_LINE_PIXELS];
   pixel_type        middle_mem [MAX_LINE_PIXELS];

   pixel_type [WIN_COLS_KEPT-1:0] win_col_ff;

   // stage 2: assembled window
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_row_end_ff;
   logic             s2_frame_end_ff;
   pixel_type [WIN_TAPS-1:0] s2_win_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the frame size into its working range
   always_comb begin
      width_ext = SW'(frame_width_ff);
      if (width_ext < SW'(MIN_SIZE)) begin
         width_clamped = SW'(MIN_SIZE);
      end else if (width_ext > SW'(MAX_LINE_PIXELS)) begin
         width_clamped = SW'(MAX_LINE_PIXELS);
      end else begin
         width_clamped = width_ext;
      end

      if (frame_height_ff < CSR_W'(MIN_SIZE)) begin
         height_clamped = CSR_W'(MIN_SIZE);
      end else if (frame_height_ff > CSR_W'(HEIGHT_LIMIT)) begin
         height_clamped = CSR_W'(HEIGHT_LIMIT);
      end else begin
         height_clamped = frame_height_ff;
      end
   end

   assign last_col = (SW'(col_ff) + SW'(1)) >= width_clamped;
   assign last_row = (CSR_W'(row_ff) + CSR_W'(1)) >= height_clamped;
   assign emit     = (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2));

   assign s1_leave  = s1_valid_ff && (!s1_emit_ff || !s2_valid_ff || win_take);
   assign req_ready = !s1_valid_ff || s1_leave;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_leave) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s1_leave && s1_emit_ff) begin
         s2_valid_in = 1'b1;
      end else if (win_take) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         win_col_ff  <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         // shift the window columns along once the word leaves stage 1
         if (s1_leave) begin
            win_col_ff <= {s1_pix_ff, mid_rd_ff, top_rd_ff, win_col_ff[5:3]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff     <= emit;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_idx_ff      <= col_ff;
         s1_pix_ff      <= pix_in;
      end
      if (s1_leave && s1_emit_ff) begin
         s2_win_ff       <= {s1_pix_ff, mid_rd_ff, top_rd_ff, win_col_ff};
         s2_row_end_ff   <= s1_last_col_ff;
         s2_frame_end_ff <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   // line stores: write back as the word leaves stage 1, read on accept
   always_ff @(posedge clock) begin
      if (s1_leave) begin
         upper_mem[s1_idx_ff] <= mid_rd_ff;
      end
      if (accept) begin
         top_rd_ff <= upper_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         middle_mem[s1_idx_ff] <= s1_pix_ff;
      end
      if (accept) begin
         mid_rd_ff <= middle_mem[col_ff];
      end
   end

   assign win_status.valid     = s2_valid_ff;
   assign win_status.row_end   = s2_row_end_ff;
   assign win_status.frame_end = s2_frame_end_ff;
   assign win_out              = s2_win_ff;

endmodule

[hdl/rmf_median_lane.sv]
// ----------------------------------------------------------------------------
// rmf_median_lane: median of nine 8-bit values for one colour channel
// Nineteen compare-exchange cells split over two levels: row sorts are
// registered, the remaining cells settle after the register and feed the
// merge register in the top level.
// ----------------------------------------------------------------------------
module rmf_median_lane
   import rmf_pkg::*;
(
   input  logic                    clock,
   input  logic                    load,
   input  chan_type [WIN_TAPS-1:0] win_in,
   output chan_type                median
);

   chan_type p [WIN_TAPS];
   chan_type q [WIN_TAPS];
   chan_type stage_ff [WIN_TAPS];

   // returns {max, min}
   function automatic chan_type [1:0] cas(input chan_type a, input chan_type b);
      return (a > b) ? {a, b} : {b, a};
   endfunction

   // sort each group of three
   always_comb begin
      for (int k = 0; k < WIN_TAPS; k++) begin
         p[k] = win_in[k];
      end
      {p[2], p[1]} = cas(p[1], p[2]);
      {p[5], p[4]} = cas(p[4], p[5]);
      {p[8], p[7]} = cas(p[7], p[8]);
      {p[1], p[0]} = cas(p[0], p[1]);
      {p[4], p[3]} = cas(p[3], p[4]);
      {p[7], p[6]} = cas(p[6], p[7]);
      {p[2], p[1]} = cas(p[1], p[2]);
      {p[5], p[4]} = cas(p[4], p[5]);
      {p[8], p[7]} = cas(p[7], p[8]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= p;
      end
   end

   // max of mins, median of medians, min of maxes, then the final three
   always_comb begin
      for (int k = 0; k < WIN_TAPS; k++) begin
         q[k] = stage_ff[k];
      end
      {q[3], q[0]} = cas(q[0], q[3]);
      {q[8], q[5]} = cas(q[5], q[8]);
      {q[7], q[4]} = cas(q[4], q[7]);
      {q[6], q[3]} = cas(q[3], q[6]);
      {q[4], q[1]} = cas(q[1], q[4]);
      {q[5], q[2]} = cas(q[2], q[5]);
      {q[7], q[4]} = cas(q[4], q[7]);
      {q[2], q[4]} = cas(q[4], q[2]);
      {q[4], q[6]} = cas(q[6], q[4]);
      {q[2], q[4]} = cas(q[4], q[2]);
   end

   assign median = q[4];

endmodule

[hdl/rgb_median_filter_3x3.sv]
// Pipeline: the bottom-right pixel of a window passes stage 1, the window
//    register, the lane registers and the merge register to the result word.
// Throughput: one pixel word per cycle unless rsp_ready stalls the result;
//    set by the single write and read port of each line store and the two-level median lanes.
// Reset: synchronous; empties the pipeline, zeroes counters and window
//    columns, loads width 320 and height 240. Line stores are not cleared.
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3: 3x3 median filter on a raster RGB pixel stream
// Window builder feeds three channel lanes in parallel; the merge register
// joins their medians with the row and frame end flags.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3
   import rmf_pkg::*;
#(
   parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_red,
   input  logic [7:0]       req_green,
   input  logic [7:0]       req_blue,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_red_median,
   output logic [7:0]       rsp_green_median,
   output logic [7:0]       rsp_blue_median,
   output logic             rsp_row_end,
   output logic             rsp_frame_end
);

   pixel_type                pix_in;
   win_status_type           win_status;
   pixel_type [WIN_TAPS-1:0] win;
   chan_type  [WIN_TAPS-1:0] red_win;
   chan_type  [WIN_TAPS-1:0] green_win;
   chan_type  [WIN_TAPS-1:0] blue_win;
   chan_type                 red_med;
   chan_type                 green_med;
   chan_type                 blue_med;

   logic     win_take;
   logic     lane_valid_ff, lane_valid_in;
   logic     lane_row_end_ff;
   logic     lane_frame_end_ff;
   logic     out_load;
   logic     out_valid_ff, out_valid_in;
   chan_type red_out_ff;
   chan_type green_out_ff;
   chan_type blue_out_ff;
   logic     row_end_out_ff;
   logic     frame_end_out_ff;

   assign pix_in.red   = req_red;
   assign pix_in.green = req_green;
   assign pix_in.blue  = req_blue;

   rmf_window #(
      .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .pix_in     (pix_in),
      .win_take   (win_take),
      .win_status (win_status),
      .win_out    (win)
   );

   always_comb begin
      for (int k = 0; k < WIN_TAPS; k++) begin
         red_win[k]   = win[k].red;
         green_win[k] = win[k].green;
         blue_win[k]  = win[k].blue;
      end
   end

   // hand the word on only where the next stage is free or draining
   assign out_load = lane_valid_ff && (!out_valid_ff || rsp_ready);
   assign win_take = win_status.valid && (!lane_valid_ff || out_load);

   rmf_median_lane u_lane_red (
      .clock  (clock),
      .load   (win_take),
      .win_in (red_win),
      .median (red_med)
   );

   rmf_median_lane u_lane_green (
      .clock  (clock),
      .load   (win_take),
      .win_in (green_win),
      .median (green_med)
   );

   rmf_median_lane u_lane_blue (
      .clock  (clock),
      .load   (win_take),
      .win_in (blue_win),
      .median (blue_med)
   );

   always_comb begin
      lane_valid_in = lane_valid_ff;
      if (win_take) begin
         lane_valid_in = 1'b1;
      end else if (out_load) begin
         lane_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_take) begin
         lane_row_end_ff   <= win_status.row_end;
         lane_frame_end_ff <= win_status.frame_end;
      end
      // merge the three lanes into the result word
      if (out_load) begin
         red_out_ff       <= red_med;
         green_out_ff     <= green_med;
         blue_out_ff      <= blue_med;
         row_end_out_ff   <= lane_row_end_ff;
         frame_end_out_ff <= lane_frame_end_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_red_median   = red_out_ff;
   assign rsp_green_median = green_out_ff;
   assign rsp_blue_median  = blue_out_ff;
   assign rsp_row_end      = row_end_out_ff;
   assign rsp_frame_end    = frame_end_out_ff;

endmodule

[hdl/rmf_checker.sv]
// ----------------------------------------------------------------------------
// rmf_checker: port-level checks of the RGB 3x3 median filter
// Watches the result channel for held words, consistent end flags and an
// empty pipeline after reset, and the input channel for an open entry.
// ----------------------------------------------------------------------------
module rmf_checker
   import rmf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red_median,
   input logic [7:0] rsp_green_median,
   input logic [7:0] rsp_blue_median,
   input logic       rsp_row_end,
   input logic       rsp_frame_end
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_median)
         && $stable(rsp_green_median) && $stable(rsp_blue_median)
         && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("result word changed while stalled");

   // the last pixel of a frame is also the last of its row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_frame_end || rsp_row_end)
      else $error("frame end without row end");

   // reset empties the pipeline: no word can reach the output until one has passed through it
   assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result word too soon after reset");

   // a word reaches the output only through the pipeline
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("result word appeared straight out of reset");

   // an emptied pipeline takes an offered pixel word straight away
   assert property (@(posedge clock)
      reset |=> !req_valid || req_ready)
      else $error("input held off after reset");

endmodule

bind rgb_median_filter_3x3 rmf_checker u_rmf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_red_median   (rsp_red_median),
   .rsp_green_median (rsp_green_median),
   .rsp_blue_median  (rsp_blue_median),
   .rsp_row_end      (rsp_row_end),
   .rsp_frame_end    (rsp_frame_end)
);
